// ===== hw/rtl/hrsp_pkg.sv =====
package hrsp_pkg;

  typedef enum logic [3:0] {
    PH_METHOD,
    PH_BLANK1,
    PH_URL,
    PH_BLANK2,
    PH_VERSION,
    PH_GAP,
    PH_KEY,
    PH_COLON,
    PH_VALUE,
    PH_BODY,
    PH_DONE,
    PH_ERROR
  } phase_t;

  // where a header line stood when its last CR arrived
  typedef enum logic [1:0] {
    SUB_GAP,
    SUB_KEY,
    SUB_COLON,
    SUB_VALUE
  } sub_t;

  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [2:0] ROLE_METHOD  = 3'd0;
  localparam logic [2:0] ROLE_URL     = 3'd1;
  localparam logic [2:0] ROLE_VERSION = 3'd2;
  localparam logic [2:0] ROLE_SEP     = 3'd3;
  localparam logic [2:0] ROLE_KEY     = 3'd4;
  localparam logic [2:0] ROLE_VALUE   = 3'd5;
  localparam logic [2:0] ROLE_BODY    = 3'd6;
  localparam logic [2:0] ROLE_IGNORED = 3'd7;

  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_LINE_OK      = 3'd1;
  localparam logic [2:0] EV_HDR_DONE     = 3'd2;
  localparam logic [2:0] EV_BODY_DONE    = 3'd3;
  localparam logic [2:0] EV_ERR_400      = 3'd4;
  localparam logic [2:0] EV_ERR_413      = 3'd5;
  localparam logic [2:0] EV_HDR_NO_BODY  = 3'd6;

  localparam logic [2:0] M_GET    = 3'd0;
  localparam logic [2:0] M_PUT    = 3'd1;
  localparam logic [2:0] M_HEAD   = 3'd2;
  localparam logic [2:0] M_POST   = 3'd3;
  localparam logic [2:0] M_DELETE = 3'd4;
  localparam int         NUM_METHODS = 5;

  localparam logic [4:0] KEY_LEN  = 5'd14;
  localparam logic [4:0] KEY_FAIL = 5'd31;

  localparam logic [15:0] LIMIT_RESET = 16'd2048;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [2:0]  event_code;
    logic [2:0]  method_code;
    logic [31:0] content_length;
    logic [31:0] body_bytes_seen;
  } res_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SP) || (b == CH_TAB);
  endfunction

  function automatic logic is_brk(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

  function automatic logic is_key_start(input logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || (b == "-");
  endfunction

  function automatic logic [2:0] method_size(input logic [2:0] m);
    logic [2:0] len;
    case (m)
      M_GET, M_PUT:   len = 3'd3;
      M_HEAD, M_POST: len = 3'd4;
      M_DELETE:       len = 3'd6;
      default:        len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] method_char(input logic [2:0] m, input logic [2:0] idx);
    logic [47:0] name;
    case (m)
      M_GET:    name = {"GET", 24'h0};
      M_PUT:    name = {"PUT", 24'h0};
      M_HEAD:   name = {"HEAD", 16'h0};
      M_POST:   name = {"POST", 16'h0};
      M_DELETE: name = "DELETE";
      default:  name = 48'h0;
    endcase
    if (idx < 3'd6) begin
      return name[8'd47 - {idx, 3'b000} -: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [7:0] cl_key(input logic [3:0] idx);
    logic [111:0] key;
    key = "content-length";
    if (idx < 4'd14) begin
      return key[8'd111 - {1'b0, idx, 3'b000} -: 8];
    end
    return 8'h00;
  endfunction

  function automatic logic [4:0] key_step(input logic [4:0] pos, input logic [7:0] b);
    logic [7:0] lc;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (pos < KEY_LEN && lc == cl_key(pos[3:0])) begin
      return pos + 5'd1;
    end
    return KEY_FAIL;
  endfunction

  function automatic sub_t phase_sub(input phase_t ph);
    sub_t s;
    case (ph)
      PH_KEY:   s = SUB_KEY;
      PH_COLON: s = SUB_COLON;
      PH_VALUE: s = SUB_VALUE;
      default:  s = SUB_GAP;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/http_request_stream_parser.sv =====
// HTTP/1.1 request parser, one byte per request on the req channel.
// req carries opcode and data_byte: opcode data classifies one byte of
// the request, opcode restart clears the parse for the next request.
// Every request gives exactly one result on the res channel: the byte's
// role, an event (line ok, headers done, body complete, error 400/413),
// the accepted method, the Content-Length value and the body byte count.
// cfg is a write-only port for header_byte_limit; write it only while
// the parser is idle. cfg_ready is always high.
// An accepted request waits in the input register until res can take
// it, then is parsed into the result register. Throughput: one byte per
// cycle while res is not stalled; the per-byte parse is one pass of
// small compare and add logic between the input and result registers.
// A stalled res holds its result; one more request is still taken into
// the input register, after which req_stall rises until res drains.
// Reset (rst, synchronous) clears the parse state, empties both
// registers and sets header_byte_limit back to 2048.
module http_request_stream_parser
  import hrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        res_valid,
  input  logic        res_stall,
  output res_t        res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0] header_byte_limit;

  req_t        req_q;
  logic        req_q_valid;
  logic        advance;

  phase_t      parse_phase, parse_phase_next;
  logic [4:0]  method_flags, method_flags_next;
  logic [2:0]  method_count, method_count_next;
  logic [23:0] recent_bytes, recent_bytes_next;
  sub_t        sub_phase, sub_phase_next;
  logic [15:0] received_count, received_count_next;
  logic [4:0]  key_pos, key_pos_next;
  logic [31:0] length_acc, length_acc_next;
  logic [31:0] body_count, body_count_next;
  logic [2:0]  accepted_method, accepted_method_next;

  logic [7:0]  b;
  logic        in_header, hdr, block_end, method_ok;
  logic [4:0]  len_sel;
  logic [15:0] count_inc;
  logic [31:0] body_inc, acc_digit;
  logic [2:0]  role, ev, ev_line;
  logic        stays_key;

  assign cfg_ready = 1'b1;
  assign advance   = req_q_valid && (!res_valid || !res_stall);
  assign req_stall = req_q_valid && !advance;

  assign b         = req_q.data_byte;
  assign in_header = (parse_phase <= PH_VALUE);
  assign hdr       = (parse_phase >= PH_GAP) && in_header;
  assign block_end = (recent_bytes == {CH_CR, CH_LF, CH_CR}) && (b == CH_LF);
  assign count_inc = received_count + 16'd1;
  assign body_inc  = body_count + 32'd1;
  assign acc_digit = {length_acc[28:0], 3'b000} + {length_acc[30:0], 1'b0}
                   + {24'd0, b} - {24'd0, CH_ZERO};

  always_comb begin
    for (int m = 0; m < NUM_METHODS; m++) begin
      len_sel[m] = method_flags[m] && (method_size(3'(m)) == method_count);
    end
  end
  assign method_ok = (method_count != 3'd0) && (len_sel != 5'd0);

  // role and event of the byte in the input register
  always_comb begin
    role      = ROLE_IGNORED;
    ev_line   = EV_NONE;
    ev        = EV_NONE;
    stays_key = 1'b0;
    if (req_q.opcode == OP_DATA) begin
      if (parse_phase == PH_BODY) begin
        role = ROLE_BODY;
        if (body_inc == length_acc) begin
          ev = EV_BODY_DONE;
        end
      end else if (in_header) begin
        unique case (parse_phase)
          PH_METHOD: begin
            if (is_brk(b)) begin
              role    = ROLE_SEP;
              ev_line = EV_ERR_400;
            end else if (is_blank(b)) begin
              role    = ROLE_SEP;
              ev_line = method_ok ? EV_NONE : EV_ERR_400;
            end else begin
              role = ROLE_METHOD;
            end
          end
          PH_BLANK1, PH_BLANK2: begin
            if (is_brk(b)) begin
              role    = ROLE_SEP;
              ev_line = EV_ERR_400;
            end else if (is_blank(b)) begin
              role = ROLE_SEP;
            end else begin
              role = (parse_phase == PH_BLANK1) ? ROLE_URL : ROLE_VERSION;
            end
          end
          PH_URL: begin
            if (is_brk(b)) begin
              role    = ROLE_SEP;
              ev_line = EV_ERR_400;
            end else if (is_blank(b)) begin
              role = ROLE_SEP;
            end else begin
              role = ROLE_URL;
            end
          end
          PH_VERSION: begin
            if (is_blank(b)) begin
              role    = ROLE_SEP;
              ev_line = EV_ERR_400;
            end else if (is_brk(b)) begin
              role    = ROLE_SEP;
              ev_line = EV_LINE_OK;
            end else begin
              role = ROLE_VERSION;
            end
          end
          PH_GAP: begin
            if (is_brk(b)) begin
              role = ROLE_SEP;
            end else if (is_key_start(b)) begin
              role      = ROLE_KEY;
              stays_key = 1'b1;
            end else begin
              role    = ROLE_KEY;
              ev_line = EV_ERR_400;
            end
          end
          PH_KEY: begin
            if (b == CH_COLON) begin
              role = ROLE_SEP;
            end else begin
              role      = ROLE_KEY;
              stays_key = 1'b1;
            end
          end
          PH_COLON, PH_VALUE: begin
            if (is_blank(b) && parse_phase == PH_COLON) begin
              role = ROLE_SEP;
            end else if (is_brk(b)) begin
              role = ROLE_SEP;
            end else begin
              role = ROLE_VALUE;
            end
          end
          default: begin
            role = ROLE_IGNORED;
          end
        endcase

        if (ev_line != EV_ERR_400 && hdr && block_end) begin
          // key still open, or nothing but blanks after the colon
          if (stays_key || sub_phase == SUB_COLON) begin
            ev = EV_ERR_400;
          end else if (length_acc == 32'd0) begin
            ev = EV_HDR_NO_BODY;
          end else begin
            ev = EV_HDR_DONE;
          end
        end else if (ev_line != EV_ERR_400 && count_inc >= header_byte_limit) begin
          ev = EV_ERR_413;
        end else begin
          ev = ev_line;
        end
      end
    end
  end

  // next parse state
  always_comb begin
    parse_phase_next     = parse_phase;
    method_flags_next    = method_flags;
    method_count_next    = method_count;
    recent_bytes_next    = recent_bytes;
    sub_phase_next       = sub_phase;
    received_count_next  = received_count;
    key_pos_next         = key_pos;
    length_acc_next      = length_acc;
    body_count_next      = body_count;
    accepted_method_next = accepted_method;

    if (req_q.opcode == OP_RESTART) begin
      parse_phase_next     = PH_METHOD;
      method_flags_next    = '1;
      method_count_next    = '0;
      recent_bytes_next    = '0;
      sub_phase_next       = SUB_GAP;
      received_count_next  = '0;
      key_pos_next         = '0;
      length_acc_next      = '0;
      body_count_next      = '0;
      accepted_method_next = M_GET;
    end else if (parse_phase == PH_BODY) begin
      body_count_next = body_inc;
      if (ev == EV_BODY_DONE) begin
        parse_phase_next = PH_DONE;
      end
    end else if (in_header) begin
      received_count_next = count_inc;
      recent_bytes_next   = {recent_bytes[15:0], b};
      if (hdr && b == CH_CR && recent_bytes[15:0] != {CH_CR, CH_LF}) begin
        sub_phase_next = phase_sub(parse_phase);
      end

      unique case (parse_phase)
        PH_METHOD: begin
          if (!is_brk(b) && !is_blank(b)) begin
            for (int m = 0; m < NUM_METHODS; m++) begin
              if (!(method_count < method_size(3'(m)) &&
                    method_char(3'(m), method_count) == b)) begin
                method_flags_next[m] = 1'b0;
              end
            end
            if (method_count != 3'd7) begin
              method_count_next = method_count + 3'd1;
            end
          end else if (is_blank(b) && method_ok) begin
            method_flags_next = len_sel;
            parse_phase_next  = PH_BLANK1;
          end
        end
        PH_BLANK1: begin
          if (!is_brk(b) && !is_blank(b)) begin
            parse_phase_next = PH_URL;
          end
        end
        PH_BLANK2: begin
          if (!is_brk(b) && !is_blank(b)) begin
            parse_phase_next = PH_VERSION;
          end
        end
        PH_URL: begin
          if (!is_brk(b) && is_blank(b)) begin
            parse_phase_next = PH_BLANK2;
          end
        end
        PH_VERSION: begin
          if (!is_blank(b) && is_brk(b)) begin
            if (method_flags[0]) begin
              accepted_method_next = M_GET;
            end else if (method_flags[1]) begin
              accepted_method_next = M_PUT;
            end else if (method_flags[2]) begin
              accepted_method_next = M_HEAD;
            end else if (method_flags[3]) begin
              accepted_method_next = M_POST;
            end else begin
              accepted_method_next = M_DELETE;
            end
            parse_phase_next = PH_GAP;
            sub_phase_next   = SUB_GAP;
          end
        end
        PH_GAP: begin
          if (!is_brk(b) && is_key_start(b)) begin
            key_pos_next     = key_step(5'd0, b);
            parse_phase_next = PH_KEY;
          end
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            if (key_pos != KEY_LEN) begin
              key_pos_next = KEY_FAIL;
            end
            parse_phase_next = PH_COLON;
          end else begin
            key_pos_next = key_step(key_pos, b);
          end
        end
        PH_COLON: begin
          if (is_blank(b)) begin
            parse_phase_next = PH_COLON;
          end else if (is_brk(b)) begin
            parse_phase_next = PH_GAP;
          end else begin
            if (key_pos == KEY_LEN) begin
              length_acc_next = acc_digit;
            end
            parse_phase_next = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (is_brk(b)) begin
            parse_phase_next = PH_GAP;
          end else if (key_pos == KEY_LEN) begin
            length_acc_next = acc_digit;
          end
        end
        default: begin
          parse_phase_next = parse_phase;
        end
      endcase

      // events override the phase the byte alone would leave
      if (ev == EV_ERR_400 || ev == EV_ERR_413) begin
        parse_phase_next = PH_ERROR;
      end else if (ev == EV_HDR_NO_BODY) begin
        parse_phase_next = PH_DONE;
        body_count_next  = '0;
      end else if (ev == EV_HDR_DONE) begin
        parse_phase_next = PH_BODY;
        body_count_next  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte_limit <= LIMIT_RESET;
      req_q_valid       <= 1'b0;
      res_valid         <= 1'b0;
      parse_phase       <= PH_METHOD;
      method_flags      <= '1;
      method_count      <= '0;
      recent_bytes      <= '0;
      sub_phase         <= SUB_GAP;
      received_count    <= '0;
      key_pos           <= '0;
      length_acc        <= '0;
      body_count        <= '0;
      accepted_method   <= M_GET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        header_byte_limit <= cfg_data;
      end

      if (req_valid && !req_stall) begin
        req_q_valid <= 1'b1;
      end else if (advance) begin
        req_q_valid <= 1'b0;
      end

      if (advance) begin
        res_valid       <= 1'b1;
        parse_phase     <= parse_phase_next;
        method_flags    <= method_flags_next;
        method_count    <= method_count_next;
        recent_bytes    <= recent_bytes_next;
        sub_phase       <= sub_phase_next;
        received_count  <= received_count_next;
        key_pos         <= key_pos_next;
        length_acc      <= length_acc_next;
        body_count      <= body_count_next;
        accepted_method <= accepted_method_next;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload registers: load on accept or advance only
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
    if (advance) begin
      res.byte_role       <= role;
      res.event_code      <= ev;
      res.method_code     <= accepted_method_next;
      res.content_length  <= length_acc_next;
      res.body_bytes_seen <= body_count_next;
    end
  end

endmodule

// ===== dv/http_request_stream_parser_tb.sv =====
`timescale 1ns / 100ps

module http_request_stream_parser_tb
  import hrsp_pkg::*;
();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int NUM_PHASES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  http_request_stream_parser uut (
    .clk,
    .rst,
    .req_valid,
    .req_stall,
    .req,
    .res_valid,
    .res_stall,
    .res,
    .cfg_valid,
    .cfg_ready,
    .cfg_data
  );

  always #2 clk = ~clk;

  // parser state as the block should hold it
  phase_t      phase;
  logic [4:0]  verb_flags;
  logic [2:0]  verb_len;
  logic [23:0] last_bytes;
  sub_t        cr_sub;
  int unsigned hdr_count;
  logic [4:0]  key_pos;
  logic [31:0] clen;
  logic [31:0] body_count;
  logic [2:0]  verb_sel;
  logic [15:0] header_limit = LIMIT_RESET;

  string verbs [NUM_METHODS] = '{"GET", "PUT", "HEAD", "POST", "DELETE"};
  string cl_name = "content-length";

  req_t pending_reqs[$];
  res_t expected_results[$];

  int cycle_count = 0;
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int cfg_writes = 0;
  int queued_count = 0;
  int event_seen [8];
  bit req_out = 1'b0;
  bit req_taken = 1'b0;
  bit drain_hold = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int send_quiet = 0;
  int recv_quiet = 0;

  function automatic bit blank_char(logic [7:0] b);
    return b == CH_SP || b == CH_TAB;
  endfunction

  function automatic bit line_break(logic [7:0] b);
    return b == CH_CR || b == CH_LF;
  endfunction

  function automatic bit token_start(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
           (b >= "a" && b <= "z") || b == "-";
  endfunction

  function automatic logic [4:0] cl_next(logic [4:0] pos, logic [7:0] b);
    logic [7:0] lc;
    lc = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (pos < KEY_LEN && lc == cl_name[pos]) return pos + 5'd1;
    return KEY_FAIL;
  endfunction

  function automatic void clear_parse();
    phase = PH_METHOD;
    verb_flags = 5'h1F;
    verb_len = '0;
    last_bytes = '0;
    cr_sub = SUB_GAP;
    hdr_count = 0;
    key_pos = '0;
    clen = '0;
    body_count = '0;
    verb_sel = M_GET;
  endfunction

  function automatic void add_digit(logic [7:0] b);
    if (key_pos == KEY_LEN) clen = clen * 32'd10 + {24'd0, b} - 32'd48;
  endfunction

  function automatic res_t parse_byte(req_t r);
    res_t        result;
    logic [7:0]  b;
    logic [31:0] win;
    logic [4:0]  sel;
    logic [2:0]  role;
    logic [2:0]  ev;
    logic        hdr;
    int          m;
    b = r.data_byte;
    role = ROLE_IGNORED;
    ev = EV_NONE;
    if (r.opcode == OP_RESTART) begin
      clear_parse();
    end else if (phase == PH_BODY) begin
      role = ROLE_BODY;
      body_count++;
      if (body_count == clen) begin
        ev = EV_BODY_DONE;
        phase = PH_DONE;
      end
    end else if (phase <= PH_VALUE) begin
      win = {last_bytes, b};
      hdr = phase >= PH_GAP;
      hdr_count++;
      // remember where the line stood at a CR that does not follow CR LF
      if (hdr && b == CH_CR && last_bytes[15:0] != {CH_CR, CH_LF})
        cr_sub = sub_t'(2'(phase - PH_GAP));
      last_bytes = win[23:0];
      case (phase)
        PH_METHOD: begin
          if (line_break(b)) begin
            role = ROLE_SEP;
            ev = EV_ERR_400;
          end else if (blank_char(b)) begin
            role = ROLE_SEP;
            sel = '0;
            for (m = 0; m < NUM_METHODS; m++) sel[m] = verbs[m].len() == verb_len;
            sel &= verb_flags;
            if (verb_len == 0 || sel == 0) begin
              ev = EV_ERR_400;
            end else begin
              verb_flags = sel;
              phase = PH_BLANK1;
            end
          end else begin
            role = ROLE_METHOD;
            for (m = 0; m < NUM_METHODS; m++)
              if (verb_len >= verbs[m].len() || verbs[m][verb_len] != b) verb_flags[m] = 1'b0;
            if (verb_len != 3'd7) verb_len++;
          end
        end
        PH_BLANK1, PH_BLANK2: begin
          if (line_break(b)) begin
            role = ROLE_SEP;
            ev = EV_ERR_400;
          end else if (blank_char(b)) begin
            role = ROLE_SEP;
          end else if (phase == PH_BLANK1) begin
            role = ROLE_URL;
            phase = PH_URL;
          end else begin
            role = ROLE_VERSION;
            phase = PH_VERSION;
          end
        end
        PH_URL: begin
          if (line_break(b)) begin
            role = ROLE_SEP;
            ev = EV_ERR_400;
          end else if (blank_char(b)) begin
            role = ROLE_SEP;
            phase = PH_BLANK2;
          end else begin
            role = ROLE_URL;
          end
        end
        PH_VERSION: begin
          if (blank_char(b)) begin
            role = ROLE_SEP;
            ev = EV_ERR_400;
          end else if (line_break(b)) begin
            role = ROLE_SEP;
            ev = EV_LINE_OK;
            m = 0;
            while (m < M_DELETE && !verb_flags[m]) m++;
            verb_sel = 3'(m);
            phase = PH_GAP;
            cr_sub = SUB_GAP;
          end else begin
            role = ROLE_VERSION;
          end
        end
        PH_GAP: begin
          if (line_break(b)) begin
            role = ROLE_SEP;
          end else if (token_start(b)) begin
            role = ROLE_KEY;
            key_pos = cl_next(5'd0, b);
            phase = PH_KEY;
          end else begin
            role = ROLE_KEY;
            ev = EV_ERR_400;
          end
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            role = ROLE_SEP;
            if (key_pos != KEY_LEN) key_pos = KEY_FAIL;
            phase = PH_COLON;
          end else begin
            role = ROLE_KEY;
            key_pos = cl_next(key_pos, b);
          end
        end
        PH_COLON: begin
          if (blank_char(b)) begin
            role = ROLE_SEP;
          end else if (line_break(b)) begin
            role = ROLE_SEP;
            phase = PH_GAP;
          end else begin
            role = ROLE_VALUE;
            add_digit(b);
            phase = PH_VALUE;
          end
        end
        default: begin
          if (line_break(b)) begin
            role = ROLE_SEP;
            phase = PH_GAP;
          end else begin
            role = ROLE_VALUE;
            add_digit(b);
          end
        end
      endcase
      if (ev != EV_ERR_400 && hdr && win == {CH_CR, CH_LF, CH_CR, CH_LF}) begin
        if (phase == PH_KEY || cr_sub == SUB_COLON) begin
          ev = EV_ERR_400;
        end else begin
          body_count = '0;
          if (clen == 0) begin
            ev = EV_HDR_NO_BODY;
            phase = PH_DONE;
          end else begin
            ev = EV_HDR_DONE;
            phase = PH_BODY;
          end
        end
      end else if (ev != EV_ERR_400 && hdr_count >= header_limit) begin
        ev = EV_ERR_413;
        phase = PH_ERROR;
      end
      if (ev == EV_ERR_400) phase = PH_ERROR;
    end
    result.byte_role = role;
    result.event_code = ev;
    result.method_code = verb_sel;
    result.content_length = clen;
    result.body_bytes_seen = body_count;
    return result;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(res_t got);
    res_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual role %0d event %0d",
               $time, got.byte_role, got.event_code);
      return;
    end
    want = expected_results.pop_front();
    checked++;
    event_seen[want.event_code]++;
    check_field("byte_role", 32'(want.byte_role), 32'(got.byte_role));
    check_field("event_code", 32'(want.event_code), 32'(got.event_code));
    check_field("method_code", 32'(want.method_code), 32'(got.method_code));
    check_field("content_length", want.content_length, got.content_length);
    check_field("body_bytes_seen", want.body_bytes_seen, got.body_bytes_seen);
  endfunction

  // mostly short gaps, a few long ones, and now and then a quiet stretch with none
  function automatic int idle_len(inout int quiet);
    int r;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // monitor: check results, predict each accepted request, track register writes
  always @(posedge clk) begin
    cycle_count++;
    if (!rst) begin
      if (res_valid && !res_stall) check_result(res);
      if (req_valid && !req_stall) begin
        expected_results.push_back(parse_byte(req));
        accepted++;
        req_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        header_limit = cfg_data;
        cfg_writes++;
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // driver: feed requests from the pending queue
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken) begin
        req_taken = 1'b0;
        req_out = 1'b0;
        gap_left = idle_len(send_quiet);
        if ($urandom_range(0, 199) == 0) drain_hold = 1'b1;
      end
      // hold off until every outstanding result has drained
      if (drain_hold && expected_results.size() == 0) drain_hold = 1'b0;
      if (!req_out) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!drain_hold && pending_reqs.size() != 0) begin
          req <= pending_reqs.pop_front();
          req_out = 1'b1;
        end
        req_valid <= req_out;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
      stall_left = idle_len(recv_quiet);
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    req_t r;
    r.opcode = OP_DATA;
    r.data_byte = b;
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  function automatic void queue_restart();
    req_t r;
    r.opcode = OP_RESTART;
    r.data_byte = 8'($urandom_range(0, 255));
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  function automatic void queue_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void queue_crlf();
    queue_byte(CH_CR);
    queue_byte(CH_LF);
  endfunction

  function automatic void queue_blanks(int n);
    repeat (n) queue_byte($urandom_range(0, 1) ? CH_SP : CH_TAB);
  endfunction

  function automatic logic [7:0] token_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return "-";
  endfunction

  function automatic logic [7:0] visible_char();
    return 8'($urandom_range(33, 126));
  endfunction

  // one request: mostly well formed with random content, some broken on purpose
  function automatic void queue_request();
    int          pick;
    int          n_hdr;
    int          len_at;
    int          i;
    int          j;
    int          n;
    logic [31:0] len_val;
    bit          has_len;
    string       key;
    queue_restart();
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      queue_text(verbs[$urandom_range(0, NUM_METHODS - 1)]);
    end else if (pick < 89) begin
      key = verbs[$urandom_range(0, NUM_METHODS - 1)];
      key[$urandom_range(0, key.len() - 1)] = token_char();
      queue_text(key);
    end else if (pick < 93) begin
      key = verbs[$urandom_range(0, NUM_METHODS - 1)];
      queue_text(key.substr(0, key.len() - 2));
    end else if (pick < 97) begin
      repeat ($urandom_range(1, 7)) queue_byte(token_char());
    end
    queue_blanks($urandom_range(1, 2));
    queue_byte("/");
    repeat ($urandom_range(0, 6)) queue_byte(visible_char());
    pick = $urandom_range(0, 99);
    // line break before the version
    if (pick < 4) begin
      queue_crlf();
      return;
    end
    queue_blanks($urandom_range(1, 2));
    queue_text($urandom_range(0, 1) ? "HTTP/1.1" : "HTTP/1.0");
    if (pick < 7) queue_byte(CH_SP);
    pick = $urandom_range(0, 9);
    if (pick < 8) queue_crlf();
    else queue_byte(pick == 8 ? CH_LF : CH_CR);

    has_len = 1'b0;
    len_val = '0;
    n_hdr = $urandom_range(0, 3);
    len_at = -1;
    if ($urandom_range(0, 99) < 60) begin
      len_at = $urandom_range(0, n_hdr);
      n_hdr++;
    end
    for (i = 0; i < n_hdr; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        case ($urandom_range(0, 3))
          0:       queue_byte(CH_SP);
          1:       queue_byte(CH_COLON);
          2:       queue_byte("@");
          default: queue_byte(8'($urandom_range(128, 255)));
        endcase
        queue_crlf();
        return;
      end
      if (i == len_at) begin
        key = cl_name;
        for (j = 0; j < key.len(); j++)
          if (key[j] >= "a" && key[j] <= "z" && $urandom_range(0, 1)) key[j] = key[j] - 8'd32;
      end else begin
        case ($urandom_range(0, 5))
          0: key = cl_name.substr(0, $urandom_range(0, 12));
          1: key = {cl_name, "s"};
          default: begin
            key = "";
            repeat ($urandom_range(1, 10)) key = {key, string'(token_char())};
          end
        endcase
      end
      queue_text(key);
      // key left open when the block ends
      if (pick < 4) begin
        queue_crlf();
        queue_crlf();
        return;
      end
      // key running on across a line break
      if (pick < 6) begin
        queue_crlf();
        queue_byte(token_char());
      end
      queue_byte(CH_COLON);
      queue_blanks($urandom_range(0, 2));
      // block ending right after the colon
      if (pick < 8) begin
        queue_crlf();
        queue_crlf();
        return;
      end
      if (i == len_at) begin
        has_len = 1'b1;
        j = $urandom_range(0, 99);
        if (j < 92) begin
          len_val = j < 80 ? $urandom_range(0, 40) : $urandom_range(41, 300);
          queue_text($sformatf("%0d", len_val));
        end else begin
          len_val = '1;
          repeat ($urandom_range(10, 12)) queue_byte(8'($urandom_range("0", "9")));
        end
      end else if (pick >= 12) begin
        repeat ($urandom_range(0, 12)) queue_byte(visible_char());
      end
      if ($urandom_range(0, 9) == 0) queue_byte(CH_LF);
      else queue_crlf();
    end
    queue_crlf();

    if (has_len && len_val != 0) begin
      n = len_val > 300 ? $urandom_range(0, 20) : len_val;
      pick = $urandom_range(0, 99);
      if (pick < 12) n = $urandom_range(0, n);
      else if (pick < 24) n = n + $urandom_range(1, 5);
      repeat (n) queue_byte(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 3)
      repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(0, 255)));
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || req_out || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    int target;
    target = cfg_writes + 1;
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(negedge clk); while (cfg_writes != target);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          budget [NUM_PHASES];
    logic [15:0] limits [NUM_PHASES];
    int          p;
    int          start;
    budget = '{200, 60, 150, 30, 40, 250, 160, 160};
    limits = '{16'hFFFF, 16'd16, 16'($urandom_range(20, 80)), 16'd0, 16'd7,
               LIMIT_RESET, 16'($urandom_range(100, 600)), 16'hFFFF};
    clear_parse();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // extreme bytes, unknown and empty methods, shortest complete request
    queue_restart();
    queue_byte(8'hFF);
    queue_byte(CH_SP);
    queue_byte(8'h00);
    queue_restart();
    queue_byte(CH_SP);
    queue_restart();
    queue_text("GET / HTTP/1.1");
    queue_crlf();
    queue_crlf();
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_limit(limits[p]);
      start = queued_count;
      while (queued_count - start < budget[p]) queue_request();
      wait_idle();
    end

    $display("Sent %0d requests under %0d header limits (0 to 65535), checked %0d results",
             accepted, cfg_writes + 1, checked);
    $display("Events: line ok %0d, headers %0d, no body %0d, body done %0d, 400 %0d, 413 %0d",
             event_seen[EV_LINE_OK], event_seen[EV_HDR_DONE], event_seen[EV_HDR_NO_BODY],
             event_seen[EV_BODY_DONE], event_seen[EV_ERR_400], event_seen[EV_ERR_413]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== http_request_stream_parser.f =====
hw/rtl/hrsp_pkg.sv
hw/rtl/http_request_stream_parser.sv
dv/http_request_stream_parser_tb.sv
